// ----- design/wdt_pkg.sv -----
// ----------------------------------------------------------------------------
// wdt_pkg: shared types and constants of the watchdog timer
// Command and register codes, the decoded operation and the control fields.
// ----------------------------------------------------------------------------
package wdt_pkg;

  // width of the register data bus
  localparam int unsigned DataWidth     = 16;
  // width of the prescale field and its phase counter
  localparam int unsigned PrescaleWidth = 8;
  // reset value of the reload and count registers before masking
  localparam logic [31:0] ResetCount    = 32'd32768;

  // control register bit positions
  localparam int unsigned CtlEnableBit   = 0;
  localparam int unsigned CtlIrqEnBit    = 1;
  localparam int unsigned CtlRstEnBit    = 2;
  localparam int unsigned CtlPrescaleLsb = 8;

  // item commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // register map
  typedef enum logic [1:0] {
    REG_CONTROL   = 2'd0,
    REG_RELOAD    = 2'd1,
    REG_COUNT     = 2'd2,
    REG_IRQ_CLEAR = 2'd3
  } reg_e;

  // decoded operation of the item that advances this cycle
  typedef struct packed {
    logic                 tick;
    logic                 write;
    logic                 read;
    reg_e                 sel;
    logic [DataWidth-1:0] data;
  } op_t;

  // control register fields
  typedef struct packed {
    logic                     enable;
    logic                     irq_en;
    logic                     rst_en;
    logic [PrescaleWidth-1:0] prescale;
  } ctl_t;

endpackage

// ----- design/watchdog_timer_peripheral_unit.sv -----
// ----------------------------------------------------------------------------
// watchdog_timer_peripheral_unit: watchdog timer with prescaler
// Pipeline: input register, then result register. Throughput: one item
// per cycle while the output is not stalled, set by the single-pass update
// of the counter state between the two registers.
// Reset: asynchronous, active low; disabled, reload and count at 32768,
// phases and interrupt cleared, both pipeline stages empty.
// ----------------------------------------------------------------------------
module watchdog_timer_peripheral_unit
  import wdt_pkg::*;
#(
  parameter int unsigned CLOCK_DIVIDER = 128,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           command_i,
  input  logic [1:0]           reg_select_i,
  input  logic [DataWidth-1:0] write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DataWidth-1:0] read_data_o,
  output logic                 irq_out_o,
  output logic                 reset_out_o
);

  logic                   in_valid_q, in_valid_d;
  logic [1:0]             in_cmd_q;
  logic [1:0]             in_sel_q;
  logic [DataWidth-1:0]   in_data_q;
  logic                   res_valid_q, res_valid_d;
  logic [DataWidth-1:0]   read_data_q, read_data_d;
  logic                   irq_q;
  logic                   rst_pulse_q;
  logic                   accept, advance;
  op_t                    op;
  ctl_t                   ctl;
  logic [COUNT_WIDTH-1:0] reload, count;
  logic [31:0]            reload_wide, count_wide;
  logic                   expire, irq_next, reset_pulse;

  // handshake: the held item moves on when the result register is empty or its result is taken
  assign advance    = in_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && res_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !advance);
  assign res_valid_d = advance || (res_valid_q && out_stall_i);

  // decode the held item
  always_comb begin
    op       = '0;
    op.sel   = reg_e'(in_sel_q);
    op.data  = in_data_q;
    unique case (in_cmd_q)
      CMD_TICK:  op.tick  = advance;
      CMD_WRITE: op.write = advance;
      CMD_READ:  op.read  = advance;
      default:   ;
    endcase
  end

  wdt_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .expire_i     (expire),
    .ctl_o        (ctl),
    .reload_o     (reload),
    .irq_next_o   (irq_next),
    .reset_pulse_o(reset_pulse)
  );

  wdt_timebase #(
    .CLOCK_DIVIDER(CLOCK_DIVIDER),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .ctl_i   (ctl),
    .reload_i(reload),
    .count_o (count),
    .expire_o(expire)
  );

  // read mux
  assign reload_wide = 32'(reload);
  assign count_wide  = 32'(count);
  always_comb begin
    read_data_d = '0;
    if (op.read) begin
      unique case (op.sel)
        REG_CONTROL: begin
          read_data_d[CtlEnableBit] = ctl.enable;
          read_data_d[CtlIrqEnBit]  = ctl.irq_en;
          read_data_d[CtlRstEnBit]  = ctl.rst_en;
          read_data_d[CtlPrescaleLsb +: PrescaleWidth] = ctl.prescale;
        end
        REG_RELOAD:    read_data_d = reload_wide[DataWidth-1:0];
        REG_COUNT:     read_data_d = count_wide[DataWidth-1:0];
        REG_IRQ_CLEAR: read_data_d = '0;
        default:       read_data_d = '0;
      endcase
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= command_i;
      in_sel_q  <= reg_select_i;
      in_data_q <= write_data_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      read_data_q <= read_data_d;
      irq_q       <= irq_next;
      rst_pulse_q <= reset_pulse;
    end
  end

  assign out_valid_o = res_valid_q;
  assign read_data_o = read_data_q;
  assign irq_out_o   = irq_q;
  assign reset_out_o = rst_pulse_q;

  // a moved item always lands in the result register
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_valid_q)
    else $error("advanced item lost");

  // input stage only stalls when both stages are full and the sink stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && res_valid_q && !advance)
    else $error("stall without a full pipeline");

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) &&
      $stable(irq_out_o) && $stable(reset_out_o))
    else $error("stalled result changed");

endmodule

// ----- design/wdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdt_ctrl: control, reload and interrupt registers
// Holds the programmable fields and the sticky interrupt, and forms the
// reset pulse on expiry when reset is enabled.
// ----------------------------------------------------------------------------
module wdt_ctrl
  import wdt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  op_t                    op_i,
  input  logic                   expire_i,
  output ctl_t                   ctl_o,
  output logic [COUNT_WIDTH-1:0] reload_o,
  output logic                   irq_next_o,
  output logic                   reset_pulse_o
);

  ctl_t                   ctl_q, ctl_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic                   irq_q, irq_d;

  // register writes and interrupt set/clear
  always_comb begin
    ctl_d    = ctl_q;
    reload_d = reload_q;
    irq_d    = irq_q;
    if (op_i.write) begin
      unique case (op_i.sel)
        REG_CONTROL: begin
          ctl_d.enable   = op_i.data[CtlEnableBit];
          ctl_d.irq_en   = op_i.data[CtlIrqEnBit];
          ctl_d.rst_en   = op_i.data[CtlRstEnBit];
          ctl_d.prescale = op_i.data[CtlPrescaleLsb +: PrescaleWidth];
        end
        REG_RELOAD:    reload_d = COUNT_WIDTH'(op_i.data);
        REG_COUNT:     ;
        REG_IRQ_CLEAR: irq_d = 1'b0;
        default:       ;
      endcase
    end else if (expire_i && ctl_q.irq_en) begin
      irq_d = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= '0;
      reload_q <= COUNT_WIDTH'(ResetCount);
      irq_q    <= 1'b0;
    end else begin
      ctl_q    <= ctl_d;
      reload_q <= reload_d;
      irq_q    <= irq_d;
    end
  end

  assign ctl_o         = ctl_q;
  assign reload_o      = reload_q;
  assign irq_next_o    = irq_d;
  assign reset_pulse_o = expire_i & ctl_q.rst_en;

endmodule

// ----- design/wdt_count.sv -----
// ----------------------------------------------------------------------------
// wdt_timebase: tick divider, prescaler and down counter
// Counts ticks while enabled, steps the counter once per prescaled period and
// flags expiry when a step finds the counter at one or zero.
// ----------------------------------------------------------------------------
module wdt_timebase
  import wdt_pkg::*;
#(
  parameter int unsigned CLOCK_DIVIDER = 128,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  op_t                    op_i,
  input  ctl_t                   ctl_i,
  input  logic [COUNT_WIDTH-1:0] reload_i,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic                   expire_o
);

  localparam int unsigned DivWidth = $clog2(CLOCK_DIVIDER);
  localparam logic [DivWidth-1:0] DivLast = DivWidth'(CLOCK_DIVIDER - 1);

  logic [DivWidth-1:0]      div_q, div_d;
  logic [PrescaleWidth-1:0] pre_q, pre_d;
  logic [COUNT_WIDTH-1:0]   count_q, count_d;
  logic                     step, div_wrap, pre_wrap, at_low;

  // phase and counter update
  always_comb begin
    step     = op_i.tick && ctl_i.enable;
    div_wrap = div_q >= DivLast;
    pre_wrap = pre_q >= ctl_i.prescale;
    at_low   = count_q <= COUNT_WIDTH'(1);
    expire_o = step && div_wrap && pre_wrap && at_low;
    div_d    = div_q;
    pre_d    = pre_q;
    count_d  = count_q;
    if (step) begin
      if (div_wrap) begin
        div_d = '0;
        if (pre_wrap) begin
          pre_d = '0;
          if (at_low) begin
            count_d = reload_i;
          end else begin
            count_d = count_q - COUNT_WIDTH'(1);
          end
        end else begin
          pre_d = pre_q + PrescaleWidth'(1);
        end
      end else begin
        div_d = div_q + DivWidth'(1);
      end
    end else if (op_i.write && (op_i.sel == REG_COUNT)) begin
      // feed the dog, phases are not reset
      count_d = COUNT_WIDTH'(op_i.data);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= '0;
      pre_q   <= '0;
      count_q <= COUNT_WIDTH'(ResetCount);
    end else begin
      div_q   <= div_d;
      pre_q   <= pre_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

  // divider phase never passes its last value
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q <= DivLast)
    else $error("divider phase out of range");

  // expiry only at a divider wrap
  a_expire_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expire_o |-> (div_q == DivLast) && ctl_i.enable)
    else $error("expiry outside a divider wrap");

  // disabled block holds its phases
  a_hold_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.enable |=> $stable(div_q) && $stable(pre_q))
    else $error("phases moved while disabled");

endmodule

// ----- tb/wdt_checker.sv -----
// ----------------------------------------------------------------------------
// wdt_checker: response predictor and scoreboard for the watchdog timer
// Watches both channels. Each input transfer runs through a cycle-free model
// of the watchdog: divider, prescaler, down counter, sticky interrupt and
// reset pulse. The predicted response is queued and then compared field by
// field with the next output transfer.
// ----------------------------------------------------------------------------
module wdt_checker
  import wdt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [1:0]           command_i,
  input  logic [1:0]           reg_select_i,
  input  logic [DataWidth-1:0] write_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [DataWidth-1:0] read_data_i,
  input  logic                 irq_out_i,
  input  logic                 reset_out_i,
  output int                   pending_o,
  output int                   fail_count_o,
  output int                   expiry_count_o
);

  localparam int unsigned DivTicks = 128;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq;
    logic                 reset_pulse;
  } wdt_resp_t;

  // shadow copy of the watchdog state
  logic                     wd_enable;
  logic                     wd_irq_en;
  logic                     wd_rst_en;
  logic [PrescaleWidth-1:0] wd_prescale;
  logic [DataWidth-1:0]     wd_reload;
  logic [DataWidth-1:0]     wd_count;
  logic [6:0]               wd_div_phase;
  logic [PrescaleWidth-1:0] wd_pre_phase;
  logic                     wd_irq_pending;

  wdt_resp_t response_q[$];
  wdt_resp_t exp_resp;
  int        fail_count;
  int        expiry_count;
  int        result_idx;

  assign fail_count_o   = fail_count;
  assign expiry_count_o = expiry_count;

  // print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [DataWidth-1:0] exp_val,
                                 input logic [DataWidth-1:0] got_val);
    $display("mismatch: %s on result %0d, expected %h, got %h",
             what, result_idx, exp_val, got_val);
    fail_count++;
  endtask

  // one clock tick of the divider, prescaler and down counter
  function automatic logic watchdog_tick();
    logic pulse;
    pulse = 1'b0;
    if (wd_enable) begin
      if (wd_div_phase >= 7'(DivTicks - 1)) begin
        wd_div_phase = '0;
        if (wd_pre_phase >= wd_prescale) begin
          wd_pre_phase = '0;
          if (wd_count <= 1) begin
            // expiry: reload, interrupt and reset pulse as enabled
            wd_count = wd_reload;
            expiry_count++;
            if (wd_irq_en) wd_irq_pending = 1'b1;
            if (wd_rst_en) pulse = 1'b1;
          end else begin
            wd_count = wd_count - 1'b1;
          end
        end else begin
          wd_pre_phase = wd_pre_phase + 1'b1;
        end
      end else begin
        wd_div_phase = wd_div_phase + 1'b1;
      end
    end
    return pulse;
  endfunction

  // apply one input item and return the response it causes
  function automatic wdt_resp_t step_watchdog(input logic [1:0] cmd, input logic [1:0] sel,
                                              input logic [DataWidth-1:0] data);
    wdt_resp_t resp;
    resp = '0;
    case (cmd)
      CMD_TICK: resp.reset_pulse = watchdog_tick();
      CMD_WRITE: begin
        case (sel)
          REG_CONTROL: begin
            wd_enable   = data[CtlEnableBit];
            wd_irq_en   = data[CtlIrqEnBit];
            wd_rst_en   = data[CtlRstEnBit];
            wd_prescale = data[CtlPrescaleLsb +: PrescaleWidth];
          end
          REG_RELOAD: wd_reload = data;
          REG_COUNT:  wd_count  = data;
          default:    wd_irq_pending = 1'b0;
        endcase
      end
      CMD_READ: begin
        case (sel)
          REG_CONTROL: begin
            resp.read_data[CtlEnableBit] = wd_enable;
            resp.read_data[CtlIrqEnBit]  = wd_irq_en;
            resp.read_data[CtlRstEnBit]  = wd_rst_en;
            resp.read_data[CtlPrescaleLsb +: PrescaleWidth] = wd_prescale;
          end
          REG_RELOAD: resp.read_data = wd_reload;
          REG_COUNT:  resp.read_data = wd_count;
          default:    resp.read_data = '0;
        endcase
      end
      default: ;
    endcase
    resp.irq = wd_irq_pending;
    return resp;
  endfunction

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_enable      = 1'b0;
      wd_irq_en      = 1'b0;
      wd_rst_en      = 1'b0;
      wd_prescale    = '0;
      wd_reload      = ResetCount[DataWidth-1:0];
      wd_count       = ResetCount[DataWidth-1:0];
      wd_div_phase   = '0;
      wd_pre_phase   = '0;
      wd_irq_pending = 1'b0;
      response_q.delete();
      pending_o    <= 0;
      fail_count    = 0;
      expiry_count  = 0;
      result_idx    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (response_q.size() == 0) begin
          report_mismatch("unexpected result", '0, read_data_i);
        end else begin
          exp_resp = response_q.pop_front();
          if (read_data_i !== exp_resp.read_data)
            report_mismatch("read_data", exp_resp.read_data, read_data_i);
          if (irq_out_i !== exp_resp.irq)
            report_mismatch("irq_out", DataWidth'(exp_resp.irq), DataWidth'(irq_out_i));
          if (reset_out_i !== exp_resp.reset_pulse)
            report_mismatch("reset_out", DataWidth'(exp_resp.reset_pulse),
                            DataWidth'(reset_out_i));
        end
        result_idx++;
      end
      if (in_valid_i && !in_stall_i)
        response_q.push_back(step_watchdog(command_i, reg_select_i, write_data_i));
      pending_o <= response_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the watchdog timer peripheral
// Directed register accesses first, then randomized programming sequences
// (small reload and count values, low prescale, long tick runs mixed with
// reads, feeds, interrupt clears and control changes) plus random noise.
// The sender works in bursts, the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb
  import wdt_pkg::*;
();

  localparam logic [1:0] CmdUnknown    = 2'd3;
  localparam int         RandomItems   = 1500;
  localparam int         TimeoutCycles = 400000;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic [1:0]           command      = '0;
  logic [1:0]           reg_select   = '0;
  logic [DataWidth-1:0] write_data   = '0;
  logic                 out_stall    = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [DataWidth-1:0] read_data;
  logic                 irq_out;
  logic                 reset_out;

  int pending;
  int fail_count;
  int expiry_count;

  int burst_left = 1;
  int n_ticks, n_writes, n_reads, n_unknown, random_items;
  int hold_reqs = 0;

  // clock
  always #5 clk = ~clk;

  watchdog_timer_peripheral_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .reg_select_i (reg_select),
    .write_data_i (write_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (read_data),
    .irq_out_o    (irq_out),
    .reset_out_o  (reset_out)
  );

  wdt_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .reg_select_i   (reg_select),
    .write_data_i   (write_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .read_data_i    (read_data),
    .irq_out_i      (irq_out),
    .reset_out_i    (reset_out),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .expiry_count_o (expiry_count)
  );

  // receiver: stall patterns that change over time, plus requested long hold-offs
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int hold_seen;
    int phase_cnt;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    phase_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 250);
        end
        mode_left--;
        phase_cnt++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 4) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (phase_cnt % 3 == 0);
        endcase
      end
    end
  end

  // sender gap with valid low
  task automatic idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // offer one item and wait for its transfer; bursts end in random gaps
  task automatic send(input logic [1:0] cmd, input logic [1:0] sel,
                      input logic [DataWidth-1:0] data);
    @(negedge clk);
    in_valid   <= 1'b1;
    command    <= cmd;
    reg_select <= sel;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    case (cmd)
      CMD_TICK:  n_ticks++;
      CMD_WRITE: n_writes++;
      CMD_READ:  n_reads++;
      default:   n_unknown++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      idle($urandom_range(0, 6));
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // hold the sender until every predicted response has arrived
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // random control word with a low prescale so expiries come often
  function automatic logic [DataWidth-1:0] control_word(input logic en);
    logic [DataWidth-1:0] w;
    int                   p;
    p = $urandom_range(0, 99);
    w = DataWidth'($urandom);
    w[CtlEnableBit] = en;
    if (p < 70)      w[CtlPrescaleLsb +: PrescaleWidth] = 8'd0;
    else if (p < 95) w[CtlPrescaleLsb +: PrescaleWidth] = 8'($urandom_range(1, 2));
    else             w[CtlPrescaleLsb +: PrescaleWidth] = 8'd3;
    return w;
  endfunction

  // one sequence: load, usually enable, then a tick run with random accesses
  task automatic program_and_run();
    int steps;
    int p;
    logic [DataWidth-1:0] rld;
    rld = ($urandom_range(0, 9) == 0) ? DataWidth'($urandom_range(4, 20))
                                      : DataWidth'($urandom_range(0, 3));
    send(CMD_WRITE, REG_RELOAD, rld);
    send(CMD_WRITE, REG_COUNT, DataWidth'($urandom_range(0, 3)));
    send(CMD_WRITE, REG_CONTROL, control_word($urandom_range(0, 9) != 0));
    steps = $urandom_range(60, 400);
    repeat (steps) begin
      p = $urandom_range(0, 99);
      if (p < 85)
        send(CMD_TICK, 2'($urandom), DataWidth'($urandom));
      else if (p < 90)
        send(CMD_READ, 2'($urandom), DataWidth'($urandom));
      else if (p < 93)
        send(CMD_WRITE, REG_COUNT, DataWidth'($urandom_range(0, 3)));
      else if (p < 96)
        send(CMD_WRITE, REG_IRQ_CLEAR, DataWidth'($urandom));
      else if (p < 99)
        send(CMD_WRITE, REG_CONTROL, control_word($urandom_range(0, 3) != 0));
      else
        send(CmdUnknown, 2'($urandom), DataWidth'($urandom));
      random_items++;
    end
  endtask

  // fully random items, including unknown commands
  task automatic noise();
    repeat ($urandom_range(5, 20)) begin
      send(2'($urandom), 2'($urandom), DataWidth'($urandom));
      random_items++;
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset values of every register
    send(CMD_READ, REG_CONTROL, 16'h0000);
    send(CMD_READ, REG_RELOAD, 16'hFFFF);
    send(CMD_READ, REG_COUNT, 16'h0000);
    send(CMD_READ, REG_IRQ_CLEAR, 16'hFFFF);
    // unknown command changes nothing
    send(CmdUnknown, REG_CONTROL, 16'hFFFF);
    send(CmdUnknown, REG_COUNT, 16'h0000);
    // control extremes, ignored middle bits
    send(CMD_WRITE, REG_CONTROL, 16'hFFFF);
    send(CMD_READ, REG_CONTROL, 16'h0000);
    send(CMD_WRITE, REG_CONTROL, 16'h0000);
    send(CMD_READ, REG_CONTROL, 16'hFFFF);
    // reload and count extremes
    send(CMD_WRITE, REG_RELOAD, 16'hFFFF);
    send(CMD_READ, REG_RELOAD, 16'h0000);
    send(CMD_WRITE, REG_RELOAD, 16'h0000);
    send(CMD_READ, REG_RELOAD, 16'hFFFF);
    send(CMD_WRITE, REG_COUNT, 16'hFFFF);
    send(CMD_READ, REG_COUNT, 16'h0000);
    send(CMD_WRITE, REG_COUNT, 16'h0000);
    send(CMD_READ, REG_COUNT, 16'hFFFF);
    // interrupt clear write and read
    send(CMD_WRITE, REG_IRQ_CLEAR, 16'hFFFF);
    send(CMD_READ, REG_IRQ_CLEAR, 16'h0000);
    // ticks on a disabled block hold everything
    send(CMD_TICK, REG_COUNT, 16'hFFFF);
    send(CMD_TICK, REG_CONTROL, 16'h0000);
    send(CMD_READ, REG_COUNT, 16'h0000);
    drain();

    // randomized sequences; long receiver hold-offs now and then
    hold_reqs++;
    while (random_items < RandomItems) begin
      if ($urandom_range(0, 5) == 0) drain();
      if ($urandom_range(0, 11) == 0) hold_reqs++;
      if ($urandom_range(0, 4) == 0) noise();
      else program_and_run();
    end

    // let the pipeline empty
    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d items: %0d ticks, %0d writes, %0d reads, %0d unknown commands",
             n_ticks + n_writes + n_reads + n_unknown, n_ticks, n_writes, n_reads, n_unknown);
    $display("counter expired %0d times, %0d mismatches", expiry_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[watchdog_timer_peripheral_unit] OK");
    end else begin
      $display("[watchdog_timer_peripheral_unit] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutCycles * 10);
    $display("timeout with %0d responses outstanding", pending);
    $display("[watchdog_timer_peripheral_unit] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/wdt_pkg.sv
design/wdt_ctrl.sv
design/wdt_count.sv
design/watchdog_timer_peripheral_unit.sv
tb/wdt_checker.sv
tb/tb.sv
